@@ rtl/core/strq_pkg.sv @@
`timescale 1ns / 1ps

package strq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int NODE_COUNT   = 2 * MAX_ELEMENTS;
    localparam int NODE_W       = $clog2(NODE_COUNT);
    localparam int LR_W         = NODE_W + 1;
    localparam int CNT_W        = (NODE_W + 1 > 11) ? NODE_W + 1 : 11;

    localparam int INDEX_W      = 10;
    localparam int DATA_W       = 32;
    localparam int ECOUNT_W     = 11;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [NODE_W-1:0]      node_addr_t;

    localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OP_SELECT     = 2'd1;

    localparam logic [OP_W-1:0] OP_SUM = 2'd0;
    localparam logic [OP_W-1:0] OP_MIN = 2'd1;
    localparam logic [OP_W-1:0] OP_MAX = 2'd2;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ORDER    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    localparam logic [ECOUNT_W-1:0] ECOUNT_RESET = 11'd1024;

    typedef struct packed {
        logic                     kind;
        logic [INDEX_W-1:0]       range_low;
        logic [INDEX_W-1:0]       range_high;
        logic signed [DATA_W-1:0] update_value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] answer;
        logic [STATUS_W-1:0]      status;
    } result_t;

    typedef struct packed {
        logic [ECOUNT_W-1:0] element_count;
        logic [OP_W-1:0]     op_select;
        logic                rebuild;
    } cfg_ctl_t;

    typedef struct packed {
        logic       we;
        node_addr_t waddr;
        value_t     wdata;
        node_addr_t raddr_a;
        node_addr_t raddr_b;
    } mem_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QRY,
        ST_RB_RD,
        ST_RB_WR,
        ST_FIN
    } eng_state_t;

    function automatic value_t combine(input logic [OP_W-1:0] op,
                                       input value_t a, input value_t b);
        value_t res;
        res = a + b;
        if (op == OP_MIN) begin
            res = ($signed(a) <= $signed(b)) ? a : b;
        end
        else if (op == OP_MAX) begin
            res = ($signed(a) >= $signed(b)) ? a : b;
        end
        return res;
    endfunction

    // Sign-extends or truncates the 32-bit input value to the node width.
    function automatic value_t to_node(input logic signed [DATA_W-1:0] v);
        return value_t'(v);
    endfunction

endpackage

@@ rtl/core/strq_node_ram.sv @@
`timescale 1ns / 1ps

module strq_node_ram
    import strq_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output value_t   rd_a,
    output value_t   rd_b
);

    value_t mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a <= mem[req.raddr_a];
        rd_b <= mem[req.raddr_b];
    end

endmodule

@@ rtl/core/strq_engine.sv @@
`timescale 1ns / 1ps

module strq_engine
    import strq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_ctl_t cfg,
    input  logic     item_valid,
    output logic     item_ready,
    input  item_t    item,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    eng_state_t          state_reg, state_next;
    node_addr_t          ptr_reg, ptr_next;
    logic [LR_W-1:0]     l_reg, l_next;
    logic [LR_W-1:0]     r_reg, r_next;
    value_t              acc_reg, acc_next;
    logic                have_reg, have_next;
    logic                hit_a_reg, hit_a_next;
    logic                hit_b_reg, hit_b_next;
    logic                pend_reg, pend_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    mem_req_t            mreq;
    value_t              rd_a, rd_b;

    logic [CNT_W-1:0]    live_cnt;
    logic [CNT_W-1:0]    lo_ext, hi_ext;
    node_addr_t          leaf_addr;
    value_t              a_val, b_val;
    logic                have_a;

    strq_node_ram u_ram (
        .clk  (clk),
        .req  (mreq),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    always_comb
    begin
        if (CNT_W'(cfg.element_count) > CNT_W'(MAX_ELEMENTS))
        begin
            live_cnt = CNT_W'(MAX_ELEMENTS);
        end
        else
        begin
            live_cnt = CNT_W'(cfg.element_count);
        end
        lo_ext    = CNT_W'(item.range_low);
        hi_ext    = CNT_W'(item.range_high);
        leaf_addr = node_addr_t'(MAX_ELEMENTS) + node_addr_t'(item.range_low);
    end

    // Folds the two node reads of the previous query level into the accumulator.
    always_comb
    begin
        a_val  = acc_reg;
        have_a = have_reg;
        if (hit_a_reg)
        begin
            a_val  = have_reg ? combine(cfg.op_select, acc_reg, rd_a) : rd_a;
            have_a = 1'b1;
        end
        b_val = a_val;
        if (hit_b_reg)
        begin
            b_val = have_a ? combine(cfg.op_select, a_val, rd_b) : rd_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            hit_a_reg  <= 1'b0;
            hit_b_reg  <= 1'b0;
            have_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            hit_a_reg  <= hit_a_next;
            hit_b_reg  <= hit_b_next;
            have_reg   <= have_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg      <= l_next;
        r_reg      <= r_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        acc_next    = acc_reg;
        have_next   = have_reg;
        hit_a_next  = hit_a_reg;
        hit_b_next  = hit_b_reg;
        pend_next   = pend_reg;
        status_next = status_reg;

        mreq.we      = 1'b0;
        mreq.waddr   = ptr_reg;
        mreq.wdata   = combine(cfg.op_select, rd_a, rd_b);
        mreq.raddr_a = {ptr_reg[NODE_W-2:0], 1'b0};
        mreq.raddr_b = {ptr_reg[NODE_W-2:0], 1'b1};

        item_ready = 1'b0;
        res_valid  = 1'b0;
        res.answer = DATA_W'(acc_reg);
        res.status = status_reg;

        // A change of operation outside the clearing pass needs a full rebuild.
        if (cfg.rebuild && state_reg != ST_CLEAR)
        begin
            pend_next = 1'b1;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mreq.we    = 1'b1;
                mreq.wdata = '0;
                pend_next  = 1'b0;
                ptr_next   = ptr_reg + node_addr_t'(1);
                if (ptr_reg == node_addr_t'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next  = cfg.rebuild;
                    ptr_next   = node_addr_t'(MAX_ELEMENTS - 1);
                    state_next = ST_RB_RD;
                end
                else
                begin
                    item_ready = 1'b1;
                    if (item_valid)
                    begin
                        acc_next    = '0;
                        have_next   = 1'b0;
                        hit_a_next  = 1'b0;
                        hit_b_next  = 1'b0;
                        status_next = STATUS_OK;
                        l_next      = LR_W'(MAX_ELEMENTS) + LR_W'(item.range_low);
                        r_next      = LR_W'(MAX_ELEMENTS) + LR_W'(item.range_high)
                                      + LR_W'(1);
                        if (item.kind == KIND_UPDATE)
                        begin
                            if (lo_ext >= live_cnt)
                            begin
                                status_next = STATUS_RANGE;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                mreq.we    = 1'b1;
                                mreq.waddr = leaf_addr;
                                mreq.wdata = to_node(item.update_value);
                                ptr_next   = leaf_addr >> 1;
                                state_next = ST_UPD_RD;
                            end
                        end
                        else
                        begin
                            if (lo_ext >= live_cnt || hi_ext >= live_cnt)
                            begin
                                status_next = STATUS_RANGE;
                                state_next  = ST_FIN;
                            end
                            else if (item.range_low > item.range_high)
                            begin
                                status_next = STATUS_ORDER;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_QRY;
                            end
                        end
                    end
                end
            end

            ST_UPD_RD:
            begin
                state_next = ST_UPD_WR;
            end

            ST_UPD_WR:
            begin
                mreq.we = 1'b1;
                if (ptr_reg == node_addr_t'(1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ptr_next   = ptr_reg >> 1;
                    state_next = ST_UPD_RD;
                end
            end

            ST_QRY:
            begin
                acc_next  = b_val;
                have_next = have_a | hit_b_reg;
                if (l_reg < r_reg)
                begin
                    // Left edge reads node l when odd, right edge reads r - 1 when r is odd.
                    mreq.raddr_a = node_addr_t'(l_reg);
                    mreq.raddr_b = node_addr_t'(r_reg - LR_W'(1));
                    hit_a_next   = l_reg[0];
                    hit_b_next   = r_reg[0];
                    l_next       = (l_reg + LR_W'(l_reg[0])) >> 1;
                    r_next       = r_reg >> 1;
                end
                else
                begin
                    hit_a_next = 1'b0;
                    hit_b_next = 1'b0;
                    state_next = ST_FIN;
                end
            end

            ST_RB_RD:
            begin
                if (cfg.rebuild)
                begin
                    pend_next = 1'b0;
                    ptr_next  = node_addr_t'(MAX_ELEMENTS - 1);
                end
                else
                begin
                    state_next = ST_RB_WR;
                end
            end

            ST_RB_WR:
            begin
                mreq.we = 1'b1;
                if (cfg.rebuild)
                begin
                    pend_next  = 1'b0;
                    ptr_next   = node_addr_t'(MAX_ELEMENTS - 1);
                    state_next = ST_RB_RD;
                end
                else if (ptr_reg == node_addr_t'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg - node_addr_t'(1);
                    state_next = ST_RB_RD;
                end
            end

            ST_FIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/segment_tree_range_query_top.sv @@
`timescale 1ns / 1ps

// Channel   Signals                                  Transaction
// item      item_valid / item_ready / item           one update or range query
// result    result_valid / result_ready / result     answer and status per item
// cfg       cfg_valid / cfg_ready / cfg_index, data  one register write
//
// An update takes one read and one write of the node memory per ancestor level.
// A query handles one tree level per cycle on the two read ports; errors go
// straight from idle to the result state. After reset the node memory is cleared
// before the first item is taken, and a write of op_select rebuilds the inner
// nodes. A held result stalls the engine only once the next item has its result.

module segment_tree_range_query_top
    import strq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [ECOUNT_W-1:0] ecount_reg, ecount_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic                rebuild;
    cfg_ctl_t            cfg_ctl;

    logic                res_valid;
    logic                res_ready;
    result_t             res;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        ecount_next = ecount_reg;
        op_next     = op_reg;
        rebuild     = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ELEMENT_COUNT:
                begin
                    ecount_next = cfg_data[ECOUNT_W-1:0];
                end
                REG_OP_SELECT:
                begin
                    op_next = cfg_data[OP_W-1:0];
                    rebuild = 1'b1;
                end
                default:
                begin
                    ecount_next = ecount_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecount_reg       <= ECOUNT_RESET;
            op_reg           <= OP_SUM;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ecount_reg       <= ecount_next;
            op_reg           <= op_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign cfg_ctl.element_count = ecount_reg;
    assign cfg_ctl.op_select     = op_reg;
    assign cfg_ctl.rebuild       = rebuild;

    strq_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ctl),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // The output register frees the engine as soon as its result is captured.
    assign res_ready = !result_valid_reg || result_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            result_valid_next = 1'b1;
            result_next       = res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ verif/segment_tree_range_query_top_test.sv @@
`timescale 1ns / 1ps

module segment_tree_range_query_top_test;
    import strq_pkg::*;

    localparam int PERIOD_NS = 8;
    localparam int STALL_LIMIT = 12000;
    localparam int IDLE_PERCENT = 18;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 105;

    // op_select code that the block treats as a wrapping sum.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    // Register indexes past the end of the register list.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    item_t   pending_items[$];
    result_t expected_results[$];
    int unsigned issued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    logic        steady = 1'b0;

    // Element values and register copies that the predictor works from.
    value_t              element_values[MAX_ELEMENTS];
    logic [ECOUNT_W-1:0] count_setting = ECOUNT_RESET;
    logic [OP_W-1:0]     op_setting = OP_SUM;

    segment_tree_range_query_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(PERIOD_NS / 2) clk = ~clk;

    function automatic value_t merge_values(input value_t a, input value_t b);
        case (op_setting)
            OP_MIN: return ($signed(a) <= $signed(b)) ? a : b;
            OP_MAX: return ($signed(a) >= $signed(b)) ? a : b;
            default: return a + b;
        endcase
    endfunction

    function automatic int unsigned live_elements();
        return (count_setting > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(count_setting);
    endfunction

    // Applies one transaction to the element values and returns its outcome.
    // Every operation is associative and commutative, so a query is simply the
    // combination of the current elements over the range.
    function automatic result_t apply_item(input item_t it);
        result_t     outcome;
        int unsigned live;
        value_t      acc;
        outcome = '0;
        live = live_elements();
        if (it.kind == KIND_UPDATE) begin
            if (it.range_low >= live) begin
                outcome.status = STATUS_RANGE;
            end
            else begin
                element_values[it.range_low] = value_t'(it.update_value);
            end
        end
        else if (it.range_low >= live || it.range_high >= live) begin
            outcome.status = STATUS_RANGE;
        end
        else if (it.range_low > it.range_high) begin
            outcome.status = STATUS_ORDER;
        end
        else begin
            acc = element_values[it.range_low];
            for (int i = int'(it.range_low) + 1; i <= int'(it.range_high); i++) begin
                acc = merge_values(acc, element_values[i]);
            end
            outcome.answer = acc;
        end
        return outcome;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : item_driver
        if (!rst_n) begin
            item_valid <= 1'b0;
        end
        else begin
            if (item_valid && item_ready) begin
                expected_results.push_back(apply_item(item));
                accepted_count++;
            end
            if (item_valid && !item_ready) begin
                // Hold the current transaction until it is taken.
            end
            else if (pending_items.size() != 0
                     && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else begin
                item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : result_monitor
        result_t want;
        if (!rst_n) begin
            result_ready <= 1'b0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item waiting");
                end
                else begin
                    want = expected_results.pop_front();
                    if (result.answer !== want.answer) begin
                        report_mismatch($sformatf("answer %0d, expected %0d",
                                                  result.answer, want.answer));
                    end
                    if (result.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  result.status, want.status));
                    end
                end
            end
            result_ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // The clearing pass after reset and a rebuild after an op_select write
    // are the longest gaps.
    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((item_valid && item_ready) || (result_valid && result_ready)
                || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_ELEMENT_COUNT) begin
            count_setting = data[ECOUNT_W-1:0];
        end
        else if (index == REG_OP_SELECT) begin
            op_setting = data[OP_W-1:0];
        end
    endtask

    task automatic post_item(input item_t it);
        pending_items.push_back(it);
        issued_count++;
    endtask

    task automatic post_update(input int unsigned index, input logic [DATA_W-1:0] value);
        item_t it;
        it = '0;
        it.kind = KIND_UPDATE;
        it.range_low = index[INDEX_W-1:0];
        it.range_high = INDEX_W'($urandom);
        it.update_value = value;
        post_item(it);
    endtask

    task automatic post_query(input int unsigned low, input int unsigned high);
        item_t it;
        it.kind = KIND_QUERY;
        it.range_low = low[INDEX_W-1:0];
        it.range_high = high[INDEX_W-1:0];
        it.update_value = $urandom;
        post_item(it);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (accepted_count != issued_count || expected_results.size() != 0);
    endtask

    // Mostly in-range, well-ordered transactions; the rest spans the whole
    // index field and so hits the order and range errors.
    function automatic item_t random_item(input int unsigned span);
        item_t       it;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        it.kind = 1'($urandom_range(1));
        case ($urandom_range(7))
            0: it.update_value = 32'h7FFF_FFFF;
            1: it.update_value = 32'h8000_0000;
            2: it.update_value = 32'($urandom_range(16)) - 32'd8;
            default: it.update_value = $urandom;
        endcase
        if (span != 0 && $urandom_range(99) < 85) begin
            a = $urandom_range(span - 1);
            b = $urandom_range(span - 1);
            if (a > b && $urandom_range(9) != 0) begin
                t = a;
                a = b;
                b = t;
            end
        end
        else begin
            a = $urandom_range(MAX_ELEMENTS - 1);
            b = $urandom_range(MAX_ELEMENTS - 1);
        end
        it.range_low = a[INDEX_W-1:0];
        it.range_high = b[INDEX_W-1:0];
        return it;
    endfunction

    initial begin : stimulus
        int unsigned counts[7];
        logic [OP_W-1:0] ops[7];
        foreach (element_values[i]) element_values[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default settings: wrapping sum over all 1024 elements.
        post_query(0, 1023);
        post_update(0, 32'h7FFF_FFFF);
        post_update(1023, 32'h8000_0000);
        post_update(1, 32'd1);
        post_query(0, 1023);
        post_query(0, 1);
        post_query(1023, 1023);
        post_query(7, 3);
        post_query(1023, 0);
        wait_drained();

        // A count of zero after masking rejects everything.
        write_register(REG_ELEMENT_COUNT, 16'hF800);
        write_register(REG_OP_SELECT, {14'h0, OP_SPARE});
        post_update(0, 32'd5);
        post_query(0, 0);
        post_query(3, 1);
        wait_drained();

        // A count above the tree size saturates; unlisted registers are ignored.
        write_register(REG_ELEMENT_COUNT, 16'h07FF);
        write_register(REG_OP_SELECT, {14'h3FFF, OP_MIN});
        write_register(REG_UNUSED_A, 16'h0005);
        write_register(REG_UNUSED_B, 16'hFFFF);
        post_query(0, 1023);
        post_query(2, 1022);
        post_update(1023, 32'd5);
        post_query(1000, 1023);
        wait_drained();

        // Sixteen elements under maximum; the range check wins over the order check.
        write_register(REG_ELEMENT_COUNT, 16'h7810);
        write_register(REG_OP_SELECT, {14'h0, OP_MAX});
        post_update(16, 32'd9);
        post_update(15, -32'sd7);
        post_query(0, 16);
        post_query(16, 0);
        post_query(10, 3);
        post_query(2, 15);
        post_query(15, 15);
        post_query(0, 15);
        wait_drained();

        counts = '{1024, 8, 1, 2047, 2, $urandom_range(1024, 3), $urandom_range(64, 1)};
        ops = '{OP_SUM, OP_MIN, OP_MAX, OP_SPARE, OP_MIN, OP_MAX, OP_SUM};
        for (int p = 0; p < 7; p++) begin
            write_register(REG_ELEMENT_COUNT, CFG_DATA_W'(counts[p]));
            write_register(REG_OP_SELECT, {14'h0, ops[p]});
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                post_item(random_item(live_elements()));
            end
            wait_drained();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/strq_pkg.sv
rtl/core/strq_node_ram.sv
rtl/core/strq_engine.sv
rtl/core/segment_tree_range_query_top.sv
verif/segment_tree_range_query_top_test.sv
